// ===== rtl/ulb_pkg.sv =====
// ulb_pkg: shared types, constants and the base64 alphabet for the line encoder
// used by the front, queue and back modules and by the top level
package ulb_pkg;

	localparam int B64_LINE_GROUPS = 19;
	localparam int UU_LINE_GROUPS  = 11;
	localparam int STORE_DEPTH     = 4 * UU_LINE_GROUPS;
	localparam int ADDR_W          = $clog2(STORE_DEPTH + 1);
	localparam int GRP_W           = 5;
	localparam int BYTES_W         = 6;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CHAR_NL  = 8'h0a;
	localparam logic [7:0] CHAR_PAD = 8'h3d;
	localparam logic [7:0] UU_BIAS  = 8'h20;

	localparam logic [1:0] CNT_FULL = 2'd3;

	// one complete or final short group, as handed from front to back
	typedef struct packed {
		logic [23:0] grp;
		logic [1:0]  cnt;
		logic        fin;
	} grp_job_t;

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			c = 8'h61 + {2'b00, v} - 8'd26;
		end else if (v < 6'd62) begin
			c = 8'h30 + {2'b00, v} - 8'd52;
		end else if (v == 6'd62) begin
			c = 8'h2b;
		end else begin
			c = 8'h2f;
		end
		return c;
	endfunction

endpackage

// ===== rtl/ulb_stream_if.sv =====
// ulb stream interfaces: byte input channel and character output channel
// valid/ready handshake, no package dependency
interface ulb_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface ulb_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       run_end;

	modport source (output valid, output out_char, output run_end, input ready);
	modport sink (input valid, input out_char, input run_end, output ready);
endinterface

// ===== rtl/ulb_front.sv =====
// ulb_front: accepts input bytes, holds a partial group, emits group jobs
// depends on ulb_pkg and ulb_byte_if
module ulb_front
	import ulb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	ulb_byte_if.sink    byte_in,
	input  logic        q_full,
	output logic        push,
	output grp_job_t    push_job
);

	logic [7:0] held_q [2];
	logic [1:0] held_cnt_q;
	logic       accept;
	logic       forms;
	logic [7:0] g0, g1, g2;

	assign byte_in.ready = !q_full;
	assign accept = byte_in.valid && byte_in.ready;
	assign forms  = (held_cnt_q == 2'd2) || byte_in.final_byte;
	assign push   = accept && forms;

	always_comb begin
		g0 = 8'h00;
		g1 = 8'h00;
		g2 = 8'h00;
		case (held_cnt_q)
			2'd0: g0 = byte_in.data_byte;
			2'd1: begin
				g0 = held_q[0];
				g1 = byte_in.data_byte;
			end
			default: begin
				g0 = held_q[0];
				g1 = held_q[1];
				g2 = byte_in.data_byte;
			end
		endcase
		push_job.grp = {g0, g1, g2};
		push_job.cnt = held_cnt_q + 2'd1;
		push_job.fin = byte_in.final_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
		end else if (cfg_we) begin
			held_cnt_q <= 2'd0;
		end else if (accept) begin
			if (forms) begin
				held_cnt_q <= 2'd0;
			end else begin
				held_cnt_q <= held_cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !forms) begin
			held_q[held_cnt_q[0]] <= byte_in.data_byte;
		end
	end

endmodule

// ===== rtl/ulb_queue.sv =====
// ulb_queue: short job queue between front and back
// depends on ulb_pkg
module ulb_queue
	import ulb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  grp_job_t push_job,
	input  logic     pop,
	output logic     q_valid,
	output logic     q_full,
	output grp_job_t q_job
);

	grp_job_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]    wr_ptr_q;
	logic [QPTR_W-1:0]    rd_ptr_q;
	logic [QPTR_W:0]      count_q;

	assign q_valid = count_q != '0;
	assign q_full  = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign q_job   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ===== rtl/ulb_back.sv =====
// ulb_back: turns group jobs into characters, holds the uuencode line store
// depends on ulb_pkg and ulb_char_if
module ulb_back
	import ulb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       mode,
	input  logic       q_valid,
	input  grp_job_t   q_job,
	output logic       pop,
	ulb_char_if.source char_out
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_B64,
		S_B64_NL,
		S_UU_WR,
		S_UU_LEN,
		S_UU_LINE,
		S_UU_NL
	} state_t;

	state_t              state_q;
	grp_job_t            job_q;
	logic [1:0]          idx_q;
	logic [GRP_W-1:0]    groups_q;
	logic [BYTES_W-1:0]  bytes_q;
	logic [ADDR_W-1:0]   wr_addr_q;
	logic [ADDR_W-1:0]   rd_idx_q;
	logic                flush_q;
	logic                out_valid_q;
	logic [7:0]          out_char_q;
	logic                run_end_q;

	logic [7:0]          line_mem [STORE_DEPTH];
	logic [7:0]          rd_q;
	logic                mem_we;
	logic                mem_re;
	logic [ADDR_W-1:0]   rd_addr;

	logic                slot_free;
	logic                emit;
	logic [5:0]          sym;
	logic                pad;
	logic [1:0]          last_idx;
	logic [GRP_W-1:0]    groups_inc;
	logic                b64_nl;
	logic [BYTES_W-1:0]  bytes_next;
	logic                uu_flush;

	assign char_out.valid    = out_valid_q;
	assign char_out.out_char = out_char_q;
	assign char_out.run_end  = run_end_q;

	assign slot_free  = !out_valid_q || char_out.ready;
	assign emit       = !cfg_we && slot_free &&
	                    ((state_q == S_B64) || (state_q == S_B64_NL) ||
	                     (state_q == S_UU_LEN) || (state_q == S_UU_LINE) ||
	                     (state_q == S_UU_NL));
	assign pop        = (state_q == S_IDLE) && q_valid;
	assign last_idx   = (job_q.cnt == CNT_FULL) ? 2'd3 : job_q.cnt;
	assign groups_inc = groups_q + GRP_W'(1);
	assign b64_nl     = (groups_inc >= GRP_W'(B64_LINE_GROUPS)) || job_q.fin;
	assign bytes_next = bytes_q + BYTES_W'(q_job.cnt);
	assign uu_flush   = (groups_inc >= GRP_W'(UU_LINE_GROUPS)) || q_job.fin;
	assign pad        = ((idx_q == 2'd2) && (job_q.cnt < 2'd2)) ||
	                    ((idx_q == 2'd3) && (job_q.cnt < CNT_FULL));

	always_comb begin
		case (idx_q)
			2'd0:    sym = job_q.grp[23:18];
			2'd1:    sym = job_q.grp[17:12];
			2'd2:    sym = job_q.grp[11:6];
			default: sym = job_q.grp[5:0];
		endcase
	end

	always_comb begin
		mem_we  = (state_q == S_UU_WR);
		mem_re  = 1'b0;
		rd_addr = '0;
		if (slot_free) begin
			if (state_q == S_UU_LEN) begin
				mem_re = 1'b1;
			end else if (state_q == S_UU_LINE && (rd_idx_q + 1'b1) != wr_addr_q) begin
				mem_re  = 1'b1;
				rd_addr = rd_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[wr_addr_q] <= UU_BIAS + {2'b00, sym};
		end
		if (mem_re) begin
			rd_q <= line_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= 2'd0;
			groups_q    <= '0;
			bytes_q     <= '0;
			wr_addr_q   <= '0;
			rd_idx_q    <= '0;
			flush_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_char_q  <= 8'h00;
			run_end_q   <= 1'b0;
			job_q       <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (char_out.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				groups_q  <= '0;
				bytes_q   <= '0;
				wr_addr_q <= '0;
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (q_valid) begin
							job_q <= q_job;
							idx_q <= 2'd0;
							if (mode) begin
								state_q <= S_B64;
							end else begin
								bytes_q  <= bytes_next;
								groups_q <= groups_inc;
								flush_q  <= uu_flush;
								state_q  <= S_UU_WR;
							end
						end
					end
					S_B64: begin
						if (slot_free) begin
							out_char_q  <= pad ? CHAR_PAD : b64_char(sym);
							run_end_q   <= (idx_q == 2'd3) && !b64_nl;
							idx_q       <= idx_q + 2'd1;
							if (idx_q == 2'd3) begin
								bytes_q  <= '0;
								groups_q <= b64_nl ? '0 : groups_inc;
								state_q  <= b64_nl ? S_B64_NL : S_IDLE;
							end
						end
					end
					S_B64_NL: begin
						if (slot_free) begin
							out_char_q  <= CHAR_NL;
							run_end_q   <= 1'b1;
							state_q     <= S_IDLE;
						end
					end
					S_UU_WR: begin
						wr_addr_q <= wr_addr_q + 1'b1;
						idx_q     <= idx_q + 2'd1;
						if (idx_q == last_idx) begin
							state_q <= flush_q ? S_UU_LEN : S_IDLE;
						end
					end
					S_UU_LEN: begin
						if (slot_free) begin
							out_char_q  <= UU_BIAS + {2'b00, bytes_q};
							run_end_q   <= 1'b0;
							rd_idx_q    <= '0;
							state_q     <= S_UU_LINE;
						end
					end
					S_UU_LINE: begin
						if (slot_free) begin
							out_char_q  <= rd_q;
							run_end_q   <= 1'b0;
							rd_idx_q    <= rd_idx_q + 1'b1;
							if ((rd_idx_q + 1'b1) == wr_addr_q) begin
								state_q <= S_UU_NL;
							end
						end
					end
					S_UU_NL: begin
						if (slot_free) begin
							out_char_q  <= CHAR_NL;
							run_end_q   <= 1'b1;
							groups_q    <= '0;
							bytes_q     <= '0;
							wr_addr_q   <= '0;
							state_q     <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

endmodule

// ===== rtl/uuencode_base64_line_encoder_core.sv =====
// uuencode_base64_line_encoder_core: top level of the base64 / uuencode line encoder
// depends on ulb_pkg, ulb_stream_if, ulb_front, ulb_queue, ulb_back
//
// channel    dir  word                      handshake
// byte_in    in   data_byte, final_byte     valid / ready
// char_out   out  out_char, run_end         valid / ready
// cfg        in   cfg_wdata (encoding mode) cfg_we, no handshake
//
// front takes one byte a cycle while the 4-deep group queue has room
// base64: the back pops a group, then emits four characters, and a newline after the last group of a line
// uuencode: the back pops a group, then writes its characters, one line store write per character
// line dump: length character, N stored characters (N up to 44), newline; one line store read per character
// reset clears control state and counters; the line store is not cleared
// output register holds a stalled word; the emitting states of the back wait, popping and line store writes go on
module uuencode_base64_line_encoder_core
	import ulb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	ulb_byte_if.sink   byte_in,
	ulb_char_if.source char_out
);

	logic     mode_q;
	logic     push;
	logic     pop;
	logic     q_valid;
	logic     q_full;
	grp_job_t push_job;
	grp_job_t q_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	ulb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.byte_in  (byte_in),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	ulb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_full   (q_full),
		.q_job    (q_job)
	);

	ulb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.mode     (mode_q),
		.q_valid  (q_valid),
		.q_job    (q_job),
		.pop      (pop),
		.char_out (char_out)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_full))
		else $error("group pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("group popped from empty queue");

	a_short_group_final: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_job.cnt != CNT_FULL) |-> push_job.fin)
		else $error("short group without end mark");

	a_full_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		(q_full && !pop) |=> q_full)
		else $error("queue lost an entry without pop");

endmodule
